@@ sv/sliding_window_min_max_filter_macros.svh @@
// assertion macros for the sliding window min/max filter
// expects clk and rst_n in the scope where a macro is used
`ifndef SLIDING_WINDOW_MIN_MAX_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_FILTER_MACROS_SVH

// condition must hold in the same cycle
`define SWMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the following cycle
`define SWMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/swmm_pkg.sv @@
// shared types and constants of the sliding window min/max filter
// no dependencies
`default_nettype none

package swmm_pkg;

    localparam int PIX_W     = 8;
    localparam int WS_W      = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [WS_W-1:0] WS_RESET = 6'd3;
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 1'b0,
        REG_FILTER_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic emit;
        logic emit_row_end;
        logic pop;
    } back_status_t;

endpackage

`default_nettype wire

@@ sv/sliding_window_min_max_filter.sv @@
// sliding window min/max filter over a row of 8-bit pixels, top level
// a result passes the command queue, the back sequencer and the result queue to the outputs
// throughput: one pixel per cycle within a row, one result each cycle during a row end, both
// while the result queue has room; a row end holds the back sequencer for columns min(lag, fill-1) down to 0
// reset: queues empty, fill count zero, window size 3, max mode; no clearing pass
`default_nettype none

`include "sliding_window_min_max_filter_macros.svh"

module sliding_window_min_max_filter #(
    parameter int MAX_WINDOW = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [swmm_pkg::PIX_W-1:0] pixel_in,
    input  wire logic                      row_end_in,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [swmm_pkg::PIX_W-1:0]     pixel_out,
    output logic                           row_end_out,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire swmm_pkg::cfg_reg_t        cfg_index,
    input  wire logic [swmm_pkg::WS_W-1:0] cfg_data
);

    import swmm_pkg::*;

    localparam int IW        = $clog2(MAX_WINDOW);
    localparam int CMD_W     = 11 + 3 * IW;
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] back_cmd;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    logic             res_push;
    logic             res_full;
    out_item_t        res_word;
    out_item_t        out_item;
    back_status_t     back_status;

    swmm_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_in   (pixel_in),
        .row_end_in (row_end_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_push   (cmd_push),
        .cmd_word   (front_cmd),
        .cmd_full   (cmd_full)
    );

    swmm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    swmm_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word),
        .status    (back_status)
    );

    swmm_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_item),
        .empty (empty)
    );

    assign pixel_out   = out_item.pixel;
    assign row_end_out = out_item.row_end;

    // the last result of a row leaves the sequencer idle unless a new beat was taken
    `SWMM_ASSERT_NEXT(a_row_end_idles,
        back_status.emit && back_status.emit_row_end && !back_status.pop,
        !back_status.busy, "sequencer still busy after row end")
    `SWMM_ASSERT_NOW(a_no_res_overflow, back_status.emit, !res_full,
        "result written into full queue")
    `SWMM_ASSERT_NOW(a_pop_has_cmd, back_status.pop, !cmd_empty,
        "command taken from empty queue")

endmodule

`default_nettype wire

@@ sv/swmm_fifo.sv @@
// small first-in first-out queue used between the filter stages
// standalone, no package needed
`default_nettype none

module swmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      rd_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = ((wr_ptr_reg ^ rd_ptr_reg) == {1'b1, {AW{1'b0}}});
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/swmm_front.sv @@
// front stage: config registers, row fill tracking, classifies each pixel
// into a command for the back stage; uses swmm_pkg
`default_nettype none

module swmm_front #(
    parameter int MAX_WINDOW = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [swmm_pkg::PIX_W-1:0] pixel_in,
    input  wire logic                      row_end_in,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire swmm_pkg::cfg_reg_t        cfg_index,
    input  wire logic [swmm_pkg::WS_W-1:0] cfg_data,
    output logic                           cmd_push,
    output logic [11+3*$clog2(MAX_WINDOW)-1:0] cmd_word,
    input  wire logic                      cmd_full
);

    import swmm_pkg::*;

    localparam int IW = $clog2(MAX_WINDOW);
    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (NW > WS_W) ? NW : WS_W;

    typedef struct packed {
        logic             mode;
        logic             last;
        logic             has_res;
        logic [PIX_W-1:0] pixel;
        logic [IW-1:0]    j_start;
        logic [IW-1:0]    c;
        logic [IW-1:0]    fm1;
    } cmd_t;

    logic [WS_W-1:0] ws_reg;
    logic            mode_reg;
    logic [NW-1:0]   fill_reg;
    logic [NW-1:0]   fill_next;
    logic            accept;
    logic [CW-1:0]   ws_ext;
    logic [CW-1:0]   n_eff;
    logic [CW-1:0]   n_less;
    logic [IW-1:0]   c_val;
    logic [IW-1:0]   d_val;
    logic [IW-1:0]   fm1;
    logic            fill_sat;
    cmd_t            cmd;

    assign cfg_ready = 1'b1;
    assign accept    = push & ~cmd_full;
    assign full      = cmd_full;
    assign cmd_push  = accept;

    // clamp window size to 1..MAX_WINDOW
    assign ws_ext = CW'(ws_reg);
    always_comb
    begin
        if (ws_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (ws_ext > CW'(MAX_WINDOW))
        begin
            n_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            n_eff = ws_ext;
        end
    end

    assign n_less = n_eff - 1'b1;
    assign c_val  = IW'(n_eff >> 1);
    assign d_val  = IW'(n_less >> 1);

    // fill count after this pixel, minus one
    assign fill_sat = (fill_reg == NW'(MAX_WINDOW));
    assign fm1      = fill_sat ? IW'(MAX_WINDOW - 1) : IW'(fill_reg);

    always_comb
    begin
        cmd.mode    = mode_reg;
        cmd.last    = row_end_in;
        cmd.pixel   = pixel_in;
        cmd.c       = c_val;
        cmd.fm1     = fm1;
        cmd.has_res = row_end_in | (d_val <= fm1);
        // a row end flushes from the oldest pending column that exists
        if (row_end_in && (fm1 < d_val))
        begin
            cmd.j_start = fm1;
        end
        else
        begin
            cmd.j_start = d_val;
        end
    end

    assign cmd_word = cmd;

    always_comb
    begin
        if (row_end_in)
        begin
            fill_next = '0;
        end
        else if (fill_sat)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= WS_RESET;
            mode_reg <= MODE_MAX;
            fill_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_WINDOW_SIZE: ws_reg   <= cfg_data;
                    REG_FILTER_MODE: mode_reg <= cfg_data[0];
                    default:         ws_reg   <= ws_reg;
                endcase
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/swmm_back.sv @@
// back stage: row of running max/min cells and the result sequencer
// uses swmm_pkg; takes commands from the front queue
`default_nettype none

module swmm_back #(
    parameter int MAX_WINDOW = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [11+3*$clog2(MAX_WINDOW)-1:0] cmd_word,
    input  wire logic                      cmd_empty,
    output logic                           cmd_pop,
    input  wire logic                      res_full,
    output logic                           res_push,
    output swmm_pkg::out_item_t            res_word,
    output swmm_pkg::back_status_t         status
);

    import swmm_pkg::*;

    localparam int IW = $clog2(MAX_WINDOW);

    typedef struct packed {
        logic             mode;
        logic             last;
        logic             has_res;
        logic [PIX_W-1:0] pixel;
        logic [IW-1:0]    j_start;
        logic [IW-1:0]    c;
        logic [IW-1:0]    fm1;
    } cmd_t;

    // cell t holds the extreme of the newest t+1 pixels
    logic [PIX_W-1:0] max_cells_reg [MAX_WINDOW];
    logic [PIX_W-1:0] min_cells_reg [MAX_WINDOW];

    logic          busy_reg;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] c_reg;
    logic [IW-1:0] fm1_reg;
    logic          last_reg;
    logic          mode_reg;

    cmd_t          cmd;
    logic          emit;
    logic          done;
    logic [IW:0]   reach;
    logic [IW-1:0] idx;

    assign cmd = cmd_t'(cmd_word);

    assign emit    = busy_reg & ~res_full;
    assign done    = ~last_reg | (j_reg == '0);
    assign cmd_pop = ~cmd_empty & (~busy_reg | (emit & done));

    // window reaches c columns past the result column, cut at the row start
    assign reach = {1'b0, j_reg} + {1'b0, c_reg};
    assign idx   = (reach > {1'b0, fm1_reg}) ? fm1_reg : reach[IW-1:0];

    assign res_push         = emit;
    assign res_word.pixel   = (mode_reg == MODE_MIN) ? min_cells_reg[idx] : max_cells_reg[idx];
    assign res_word.row_end = last_reg & (j_reg == '0);

    assign status.busy         = busy_reg;
    assign status.emit         = emit;
    assign status.emit_row_end = emit & res_word.row_end;
    assign status.pop          = cmd_pop;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            max_cells_reg[0] <= cmd.pixel;
            min_cells_reg[0] <= cmd.pixel;
            for (int t = 1; t < MAX_WINDOW; t++)
            begin
                max_cells_reg[t] <= (cmd.pixel > max_cells_reg[t-1]) ?
                                    cmd.pixel : max_cells_reg[t-1];
                min_cells_reg[t] <= (cmd.pixel < min_cells_reg[t-1]) ?
                                    cmd.pixel : min_cells_reg[t-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
            c_reg    <= '0;
            fm1_reg  <= '0;
            last_reg <= 1'b0;
            mode_reg <= MODE_MAX;
        end
        else if (cmd_pop)
        begin
            busy_reg <= cmd.has_res;
            j_reg    <= cmd.j_start;
            c_reg    <= cmd.c;
            fm1_reg  <= cmd.fm1;
            last_reg <= cmd.last;
            mode_reg <= cmd.mode;
        end
        else if (emit)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                j_reg <= j_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sliding_window_min_max_filter_test.sv @@
// self-checking testbench for the sliding window min/max filter
// drives pixel rows and register writes, checks every result against a local window model
// depends on swmm_pkg and sliding_window_min_max_filter
module sliding_window_min_max_filter_test;

    import swmm_pkg::*;

    localparam int WIN_DEPTH   = 32;
    localparam int HOLD_OFF    = 8;
    localparam int TAIL_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 42;
    localparam logic [WS_W-1:0] PHASE_WS [5] = '{6'd32, 6'd1, 6'd33, 6'd2, 6'd0};

    typedef enum logic {
        ROW_PIXEL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cfg_reg_t         idx;
        logic [WS_W-1:0]  data;
        logic [PIX_W-1:0] pix;
        logic             last;
        logic             typed;
        logic [PIX_W-1:0] exp_pix;
        logic             exp_last;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [PIX_W-1:0]     pixel_in;
    logic                 row_end_in;
    logic                 empty;
    logic                 pop;
    logic [PIX_W-1:0]     pixel_out;
    logic                 row_end_out;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index;
    logic [WS_W-1:0]      cfg_data;

    // window model state
    logic [PIX_W-1:0]     row_pixels [WIN_DEPTH];
    int                   row_fill;
    logic [WS_W-1:0]      win_size;
    logic                 win_mode;

    out_item_t            step_out [$];
    out_item_t            expected_pixels [$];
    int                   mismatch_count;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;

    stim_row_t directed_rows [30] = '{
        // after reset: window 3, max; a one-pixel row gives the pixel itself, marked
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'hA5, 1'b1, 1'b1, 8'hA5, 1'b1},
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd1,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
        // size zero acts as a pass-through
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h5A, 1'b1, 1'b1, 8'h5A, 1'b1},
        // only bit 0 of the mode word counts
        '{ROW_CFG,   REG_FILTER_MODE, 6'h3F, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        // oversized window saturates
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd63, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
        // even window
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd2,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h20, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h30, 1'b1, 1'b0, 8'h00, 1'b0},
        // row shorter than the lag
        '{ROW_CFG,   REG_FILTER_MODE, 6'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd8,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h33, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h44, 1'b1, 1'b0, 8'h00, 1'b0},
        // size change in mid-row
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h03, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd5,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h04, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h05, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,   REG_WINDOW_SIZE, 6'd32, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIXEL, REG_WINDOW_SIZE, 6'd0,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
    };

    sliding_window_min_max_filter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_in    (pixel_in),
        .row_end_in  (row_end_in),
        .empty       (empty),
        .pop         (pop),
        .pixel_out   (pixel_out),
        .row_end_out (row_end_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // shifts one pixel into the row and collects the results it releases in step_out
    function automatic void window_step(input logic [PIX_W-1:0] pix, input logic last);
        int               n;
        int               lead;
        int               lag;
        int               span;
        logic [PIX_W-1:0] best;
        logic [PIX_W-1:0] v;
        step_out.delete();
        n = (win_size == 0) ? 1 : ((win_size > WIN_DEPTH) ? WIN_DEPTH : int'(win_size));
        lead = n / 2;
        lag = (n - 1) / 2;
        for (int t = WIN_DEPTH - 1; t > 0; t--)
            row_pixels[t] = row_pixels[t-1];
        row_pixels[0] = pix;
        if (row_fill < WIN_DEPTH)
            row_fill++;
        // j counts back from the newest column; the flush runs oldest first
        for (int j = lag; j >= 0; j--)
        begin
            if (j != lag && !last)
                break;
            if (j >= row_fill)
                continue;
            span = j + lead + 1;
            if (span > row_fill)
                span = row_fill;
            best = row_pixels[0];
            for (int t = 1; t < span; t++)
            begin
                v = row_pixels[t];
                if (win_mode == MODE_MIN ? (v < best) : (v > best))
                    best = v;
            end
            step_out = {step_out, out_item_t'({best, last && j == 0})};
        end
        if (last)
            row_fill = 0;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last,
                              input logic typed, input out_item_t typed_res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        pixel_in <= pix;
        row_end_in <= last;
        do
            @(posedge clk);
        while (full);
        window_step(pix, last);
        if (typed)
            expected_pixels = {expected_pixels, typed_res};
        else
            foreach (step_out[i])
                expected_pixels = {expected_pixels, step_out[i]};
    endtask

    // register writes only once every pending result has drained
    task automatic write_reg(input cfg_reg_t idx, input logic [WS_W-1:0] val);
        @(negedge clk);
        push <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (HOLD_OFF) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WINDOW_SIZE)
            win_size = val;
        else
            win_mode = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: result pixel %02h row_end %0d with none expected",
                         $time, pixel_out, row_end_out);
                mismatch_count++;
            end
            else
            begin
                if (pixel_out !== expected_pixels[0].pixel)
                begin
                    $display("%0t: pixel_out expected %02h actual %02h",
                             $time, expected_pixels[0].pixel, pixel_out);
                    mismatch_count++;
                end
                if (row_end_out !== expected_pixels[0].row_end)
                begin
                    $display("%0t: row_end_out expected %0d actual %0d",
                             $time, expected_pixels[0].row_end, row_end_out);
                    mismatch_count++;
                end
                void'(expected_pixels.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int               row_len;
        int               row_pos;
        logic             last;
        logic [WS_W-1:0]  ws;
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pixel_in = '0;
        row_end_in = 1'b0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_SIZE;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        row_fill = 0;
        win_size = WS_RESET;
        win_mode = MODE_MAX;
        foreach (row_pixels[i])
            row_pixels[i] = '0;
        send_idle_pct = 38;
        recv_idle_pct = 88;
        row_len = 0;
        row_pos = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            else
                send_pixel(directed_rows[r].pix, directed_rows[r].last,
                           directed_rows[r].typed,
                           out_item_t'({directed_rows[r].exp_pix, directed_rows[r].exp_last}));
        end

        // random rows; a row may run across a register change
        for (int phase = 0; phase < 6; phase++)
        begin
            ws = (phase < 5) ? PHASE_WS[phase] : WS_W'($urandom_range(63));
            write_reg(REG_WINDOW_SIZE, ws);
            write_reg(REG_FILTER_MODE, WS_W'($urandom_range(63)));
            send_idle_pct = (phase < 2) ? 38 : ((phase < 4) ? 88 : 0);
            recv_idle_pct = (phase < 2) ? 88 : ((phase < 4) ? 38 : 0);
            repeat (PHASE_ITEMS)
            begin
                if (row_pos == 0)
                    row_len = ($urandom_range(99) < 15) ? $urandom_range(40, 30)
                                                        : $urandom_range(12, 1);
                row_pos++;
                last = (row_pos == row_len);
                send_pixel(PIX_W'($urandom_range(255)), last, 1'b0, '0);
                if (last)
                    row_pos = 0;
            end
        end

        @(negedge clk);
        push <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
